// File: rtl/dwpl_pkg.sv
`timescale 1ns / 1ps

package dwpl_pkg;

    // Storage depth of each bit queue; a power of two, at least 16.
    localparam int BUFFER_BITS_DEF = 256;

    localparam int          PADDR_W       = 3;
    localparam logic [9:0]  THRESHOLD_RST = 10'd512;
    localparam logic [15:0] INTERVAL_RST  = 16'd1;

    // Register select is paddr[2].
    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_TX_INTERVAL = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_SEND = 2'd1,
        KIND_READ = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [9:0]  pos_sample;
        logic [9:0]  neg_sample;
        logic [7:0]  tx_byte;
    } t_in_item;

    typedef struct packed {
        logic        drive_pos;
        logic        drive_neg;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic [5:0]  bytes_ready;
        logic        tx_busy;
        logic        overflow;
    } t_out_item;

endpackage

// File: rtl/dual_wire_pulse_link_transceiver.sv
`timescale 1ns / 1ps

// A request is held in the request register, then its result in the result register.
// Throughput: one request per cycle unless results stall; a request register and a
//   result register let a new request in while the previous result waits to be taken.
// Reset (synchronous, active low): queues empty, line low, space seen, tick count zero,
//   threshold 512, tx interval 1. Queue storage is not cleared; no clearing pass.
module dual_wire_pulse_link_transceiver #(
    parameter int BUFFER_BITS = dwpl_pkg::BUFFER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  dwpl_pkg::t_in_item            i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output dwpl_pkg::t_out_item           o_out_data,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwpl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dwpl_pkg::*;

    // Pointers count bits modulo 2*BUFFER_BITS; the extra MSB tells full from empty.
    // Transmit tail and receive head only ever move by whole bytes, so both stores
    // are kept as byte-wide memories indexed by pointer bits above the bit offset.
    localparam int PW = $clog2(BUFFER_BITS) + 1;
    localparam int NB = BUFFER_BITS / 8;
    localparam int IW = $clog2(NB);

    localparam logic [PW-1:0] FULL      = PW'(BUFFER_BITS);
    localparam logic [PW-1:0] SEND_MAX  = PW'(BUFFER_BITS - 8);
    localparam logic [PW-1:0] BYTE_STEP = PW'(8);
    localparam logic [PW-1:0] BIT_STEP  = PW'(1);

    // configuration
    logic [9:0]  r_threshold;
    logic [15:0] r_tx_interval;

    // request register
    logic        r_in_valid;
    t_in_item    r_in;

    // result register
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // link state
    logic [PW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [PW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic          r_space_due, n_space_due;
    logic [15:0]   r_tick_count, n_tick_count;
    logic          r_drive_pos, n_drive_pos, r_drive_neg, n_drive_neg;
    logic          r_saw_space, n_saw_space;
    logic [7:0]    r_rx_part, n_rx_part;   // receive byte being assembled

    // byte stores; the front registers hold the byte at each head
    logic [7:0]    r_tx_mem [NB];
    logic [7:0]    r_rx_mem [NB];
    logic [7:0]    r_tx_front, r_rx_front;

    logic          proc_fire;
    logic [PW-1:0] tx_used, rx_used, n_rx_used;
    logic [15:0]   tick_inc;
    logic          tx_bit;
    logic          is_bit, rx_bit;
    logic          tx_we, rx_we;
    logic [IW-1:0] tx_widx, tx_ridx, rx_widx, rx_ridx;
    logic [PW-4:0] bytes_full;
    logic          overflow, rx_valid;
    logic [7:0]    rx_byte;
    logic          cfg_we;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= THRESHOLD_RST;
            r_tx_interval <= INTERVAL_RST;
        end else if (cfg_we) begin
            case (paddr[2])
                REG_THRESHOLD:   r_threshold   <= pwdata[9:0];
                REG_TX_INTERVAL: r_tx_interval <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD:   prdata = 32'(r_threshold);
            REG_TX_INTERVAL: prdata = 32'(r_tx_interval);
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // A request is processed when the result register is free or being emptied.
    assign proc_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // ---------------- request processing ----------------
    assign tx_used  = r_tx_tail - r_tx_head;
    assign rx_used  = r_rx_tail - r_rx_head;
    // tick count saturates
    assign tick_inc = (r_tick_count != 16'hFFFF) ? r_tick_count + 16'd1 : r_tick_count;
    assign tx_bit   = r_tx_front[r_tx_head[2:0]];

    always_comb begin
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_space_due  = r_space_due;
        n_tick_count = r_tick_count;
        n_drive_pos  = r_drive_pos;
        n_drive_neg  = r_drive_neg;
        n_saw_space  = r_saw_space;
        n_rx_part    = r_rx_part;
        tx_we        = 1'b0;
        rx_we        = 1'b0;
        is_bit       = 1'b0;
        rx_bit       = 1'b0;
        overflow     = 1'b0;
        rx_valid     = 1'b0;
        rx_byte      = '0;

        if (proc_fire) begin
            case (r_in.kind)
                KIND_TICK: begin
                    // transmit slot: a bit, then a space; line holds when queue is empty
                    n_tick_count = tick_inc;
                    if (tx_used != '0 && tick_inc >= r_tx_interval) begin
                        n_tick_count = '0;
                        if (r_space_due) begin
                            n_drive_pos = 1'b0;
                            n_drive_neg = 1'b0;
                            n_space_due = 1'b0;
                        end else begin
                            n_drive_pos = tx_bit;
                            n_drive_neg = !tx_bit;
                            n_tx_head   = r_tx_head + BIT_STEP;
                            n_space_due = 1'b1;
                        end
                    end

                    // receive: classify the sample pair; start symbols are ignored
                    if (r_in.pos_sample > r_threshold) begin
                        if (r_in.neg_sample < r_threshold) begin
                            is_bit = 1'b1;
                            rx_bit = 1'b1;
                        end
                    end else if (r_in.neg_sample > r_threshold) begin
                        is_bit = 1'b1;
                        rx_bit = 1'b0;
                    end else begin
                        n_saw_space = 1'b1;
                    end

                    // a data bit counts only after a space; a full queue drops it
                    if (is_bit && r_saw_space) begin
                        n_saw_space = 1'b0;
                        if (rx_used >= FULL) begin
                            overflow = 1'b1;
                        end else begin
                            n_rx_part[r_rx_tail[2:0]] = rx_bit;
                            n_rx_tail = r_rx_tail + BIT_STEP;
                            rx_we     = (r_rx_tail[2:0] == 3'd7);
                        end
                    end
                end
                KIND_SEND: begin
                    if (tx_used > SEND_MAX) begin
                        overflow = 1'b1;
                    end else begin
                        tx_we     = 1'b1;
                        n_tx_tail = r_tx_tail + BYTE_STEP;
                    end
                end
                KIND_READ: begin
                    if (rx_used >= BYTE_STEP) begin
                        rx_byte   = r_rx_front;
                        rx_valid  = 1'b1;
                        n_rx_head = r_rx_head + BYTE_STEP;
                    end
                end
                default: ;
            endcase
        end
    end

    assign n_rx_used  = n_rx_tail - n_rx_head;
    assign bytes_full = n_rx_used[PW-1:3];

    always_comb begin
        n_out.drive_pos   = n_drive_pos;
        n_out.drive_neg   = n_drive_neg;
        n_out.rx_byte     = rx_byte;
        n_out.rx_valid    = rx_valid;
        n_out.bytes_ready = 6'(bytes_full);
        n_out.tx_busy     = (n_tx_tail != n_tx_head);
        n_out.overflow    = overflow;
    end

    always_comb begin
        if (proc_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_space_due  <= 1'b0;
            r_tick_count <= '0;
            r_drive_pos  <= 1'b0;
            r_drive_neg  <= 1'b0;
            r_saw_space  <= 1'b1;
        end else begin
            r_out_valid  <= n_out_valid;
            r_tx_head    <= n_tx_head;
            r_tx_tail    <= n_tx_tail;
            r_rx_head    <= n_rx_head;
            r_rx_tail    <= n_rx_tail;
            r_space_due  <= n_space_due;
            r_tick_count <= n_tick_count;
            r_drive_pos  <= n_drive_pos;
            r_drive_neg  <= n_drive_neg;
            r_saw_space  <= n_saw_space;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_part <= n_rx_part;
        if (proc_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- byte stores ----------------
    // The front register reads at the next head each cycle, so it always holds the
    // head byte; a write to that same byte is forwarded.
    assign tx_widx = r_tx_tail[PW-2:3];
    assign tx_ridx = n_tx_head[PW-2:3];
    assign rx_widx = r_rx_tail[PW-2:3];
    assign rx_ridx = n_rx_head[PW-2:3];

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[tx_widx] <= r_in.tx_byte;
        end
        if (tx_we && tx_widx == tx_ridx) begin
            r_tx_front <= r_in.tx_byte;
        end else begin
            r_tx_front <= r_tx_mem[tx_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[rx_widx] <= n_rx_part;
        end
        if (rx_we && rx_widx == rx_ridx) begin
            r_rx_front <= n_rx_part;
        end else begin
            r_rx_front <= r_rx_mem[rx_ridx];
        end
    end

endmodule

// File: rtl/dwpl_checker.sv
`timescale 1ns / 1ps

module dwpl_assertions (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input dwpl_pkg::t_out_item  o_out_data
);
    import dwpl_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a read that found no byte returns zero
    a_rx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.rx_valid |-> o_out_data.rx_byte == 8'd0)
        else $error("rx_byte nonzero without rx_valid");

    // the line never drives both wires high
    a_no_start_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.drive_pos && o_out_data.drive_neg))
        else $error("both transmit wires high");

    // with the result side empty, the request side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with empty result register");

endmodule

bind dual_wire_pulse_link_transceiver dwpl_assertions u_dwpl_assertions (.*);

// File: test/dwpl_checker.sv
`timescale 1ns / 1ps

module dwpl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  dwpl_pkg::t_in_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  dwpl_pkg::t_out_item           i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [dwpl_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [31:0]                   i_pwdata,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results,
    output int                            o_overflows,
    output int                            o_bytes_read
);
    import dwpl_pkg::*;

    localparam int BUF         = BUFFER_BITS_DEF;
    localparam int PTR_W       = $clog2(BUF) + 1;
    localparam int BYTE_BITS   = 8;

    // predicted link state
    logic             tx_store [BUF];
    logic             rx_store [BUF];
    logic [PTR_W-1:0] tx_rd, tx_wr, rx_rd, rx_wr;
    logic             space_pending;
    logic             space_seen;
    logic [15:0]      ticks_since;
    logic [1:0]       wire_lvl;      // bit 0 pos, bit 1 neg
    logic [9:0]       cfg_threshold;
    logic [15:0]      cfg_interval;

    t_out_item        expected_results [$];
    t_out_item        want;
    t_out_item        got;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] seen, input logic [7:0] exp);
        if (seen !== exp) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", name, seen, exp));
        end
    endtask

    task automatic predict_link_result(input t_in_item req, output t_out_item res);
        logic [PTR_W-1:0] occ;
        logic             rx_val;
        logic             accept;
        int               i;
        res    = '0;
        rx_val = 1'b0;
        accept = 1'b1;
        case (req.kind)
            KIND_TICK: begin
                // transmit slot timing
                if (ticks_since != 16'hFFFF) ticks_since++;
                occ = tx_wr - tx_rd;
                if (occ != '0 && ticks_since >= cfg_interval) begin
                    ticks_since = '0;
                    if (space_pending) begin
                        wire_lvl      = 2'b00;
                        space_pending = 1'b0;
                    end else begin
                        wire_lvl      = tx_store[tx_rd[PTR_W-2:0]] ? 2'b01 : 2'b10;
                        tx_rd++;
                        space_pending = 1'b1;
                    end
                end
                // sample classification
                if (req.pos_sample > cfg_threshold) begin
                    rx_val = 1'b1;
                    if (req.neg_sample >= cfg_threshold) accept = 1'b0;
                end else if (req.neg_sample > cfg_threshold) begin
                    rx_val = 1'b0;
                end else begin
                    space_seen = 1'b1;
                    accept     = 1'b0;
                end
                if (accept && space_seen) begin
                    space_seen = 1'b0;
                    occ = rx_wr - rx_rd;
                    if (int'(occ) >= BUF) begin
                        res.overflow = 1'b1;
                    end else begin
                        rx_store[rx_wr[PTR_W-2:0]] = rx_val;
                        rx_wr++;
                    end
                end
            end
            KIND_SEND: begin
                occ = tx_wr - tx_rd;
                if (BUF - int'(occ) < BYTE_BITS) begin
                    res.overflow = 1'b1;
                end else begin
                    for (i = 0; i < BYTE_BITS; i++) begin
                        tx_store[tx_wr[PTR_W-2:0]] = req.tx_byte[i];
                        tx_wr++;
                    end
                end
            end
            KIND_READ: begin
                occ = rx_wr - rx_rd;
                if (int'(occ) >= BYTE_BITS) begin
                    for (i = 0; i < BYTE_BITS; i++) begin
                        res.rx_byte[i] = rx_store[rx_rd[PTR_W-2:0]];
                        rx_rd++;
                    end
                    res.rx_valid = 1'b1;
                end
            end
            default: ;  // unused kind: status only
        endcase
        occ             = rx_wr - rx_rd;
        res.bytes_ready = 6'(occ >> 3);
        res.tx_busy     = (tx_wr != tx_rd);
        res.drive_pos   = wire_lvl[0];
        res.drive_neg   = wire_lvl[1];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_rd         = '0;
            tx_wr         = '0;
            rx_rd         = '0;
            rx_wr         = '0;
            space_pending = 1'b0;
            space_seen    = 1'b1;
            ticks_since   = '0;
            wire_lvl      = 2'b00;
            cfg_threshold = THRESHOLD_RST;
            cfg_interval  = INTERVAL_RST;
            expected_results.delete();
            o_errors      = 0;
            o_pending     = 0;
            o_results     = 0;
            o_overflows   = 0;
            o_bytes_read  = 0;
        end else begin
            // results first: a result never belongs to a request taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("drive_pos", 8'(got.drive_pos), 8'(want.drive_pos));
                    check_field("drive_neg", 8'(got.drive_neg), 8'(want.drive_neg));
                    check_field("rx_byte", got.rx_byte, want.rx_byte);
                    check_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
                    check_field("bytes_ready", 8'(got.bytes_ready), 8'(want.bytes_ready));
                    check_field("tx_busy", 8'(got.tx_busy), 8'(want.tx_busy));
                    check_field("overflow", 8'(got.overflow), 8'(want.overflow));
                    o_results++;
                    if (want.overflow) o_overflows++;
                    if (want.rx_valid) o_bytes_read++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_link_result(i_in_data, want);
                expected_results.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_THRESHOLD) begin
                    cfg_threshold = i_pwdata[9:0];
                end else begin
                    cfg_interval = i_pwdata[15:0];
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

// File: test/dual_wire_pulse_link_transceiver_tb.sv
`timescale 1ns / 1ps

module dual_wire_pulse_link_transceiver_tb;
    import dwpl_pkg::*;

    localparam int         CLK_HALF     = 5;
    localparam int         LIMIT_CYCLES = 400000;   // watchdog bound, well above the slowest legal run
    localparam int         HOLD_CYCLES  = 200;      // long output hold-off
    localparam int         TAIL_CYCLES  = 10;
    localparam int         FILL_BYTES   = 34;       // two bytes more than a 256-bit queue holds
    localparam int         MIX_ITEMS    = 70;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;     // no enum member; block only reports status

    // what a tick's sample pair should look like to the receive classifier
    typedef enum int {
        SMP_SPACE,
        SMP_ONE,
        SMP_ZERO,
        SMP_START,
        SMP_NOISE
    } t_sample_cls;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_out_item            out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int                   chk_errors, chk_pending, chk_results, chk_overflows, chk_bytes_read;

    // stimulus bookkeeping
    logic [9:0]           cur_threshold = THRESHOLD_RST;  // shapes samples around the threshold
    int                   gap_pct = 0;      // chance of a sender idle burst before a request
    int                   stall_pct = 0;    // chance of a receiver stall burst per cycle
    int                   hold_asked = 0;   // bumped by the sequencer to request a long hold-off
    int                   hold_served = 0;  // owned by the output-ready process
    int                   n_requests = 0;
    int                   n_writes = 0;
    int                   n_settings = 0;
    int                   cycle_count = 0;

    dual_wire_pulse_link_transceiver u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dwpl_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending),
        .o_results    (chk_results),
        .o_overflows  (chk_overflows),
        .o_bytes_read (chk_bytes_read)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output side. Random stall bursts, plus the long hold-off when asked for;
    // the hold is counted here so the sender keeps pushing requests and the
    // block backs up into its input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_served) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_served = hold_asked;
            end else if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(14, 0)) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Request with every payload bit random; only kind is pinned.
    function automatic t_in_item rand_req(input logic [1:0] kind_code);
        t_in_item r;
        r.kind       = t_kind'(kind_code);
        r.pos_sample = 10'($urandom);
        r.neg_sample = 10'($urandom);
        r.tx_byte    = 8'($urandom);
        return r;
    endfunction

    function automatic t_in_item tick_at(input int p, input int n);
        t_in_item r;
        r            = rand_req(KIND_TICK);
        r.pos_sample = 10'(p);
        r.neg_sample = 10'(n);
        return r;
    endfunction

    // Tick whose samples fall in the wanted class for the current threshold.
    // Classes that the threshold makes impossible degrade to noise.
    function automatic t_in_item tick_req(input t_sample_cls cls);
        t_in_item r;
        int       th;
        r  = rand_req(KIND_TICK);
        th = int'(cur_threshold);
        case (cls)
            SMP_SPACE: begin
                r.pos_sample = 10'($urandom_range(th, 0));
                r.neg_sample = 10'($urandom_range(th, 0));
            end
            SMP_ONE: begin
                if (th > 0 && th < 1023) begin
                    r.pos_sample = 10'($urandom_range(1023, th + 1));
                    r.neg_sample = 10'($urandom_range(th - 1, 0));
                end
            end
            SMP_ZERO: begin
                if (th < 1023) begin
                    r.pos_sample = 10'($urandom_range(th, 0));
                    r.neg_sample = 10'($urandom_range(1023, th + 1));
                end
            end
            SMP_START: begin
                if (th < 1023) begin
                    r.pos_sample = 10'($urandom_range(1023, th + 1));
                    r.neg_sample = 10'($urandom_range(1023, th));
                end
            end
            default: ;  // noise: keep the uniform samples
        endcase
        return r;
    endfunction

    // Offer one request, with an optional idle burst before it, and wait
    // for the accepting edge. Back-to-back requests keep valid high.
    task automatic issue(input t_in_item req);
        int gap;
        if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
            gap = $urandom_range(15, 1);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        n_requests++;
    endtask

    // Sender pause: drop valid and wait until every result has been checked.
    task automatic wait_all_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_THRESHOLD) cur_threshold = value[9:0];
        n_writes++;
    endtask

    // One byte on the receive wires, LSB first: space then bit, eight times.
    // A broken byte has one of its 16 ticks swapped for noise or a start.
    task automatic feed_rx_byte(input logic [7:0] value, input logic broken);
        int          spoil;
        int          k;
        t_sample_cls cls;
        spoil = broken ? int'($urandom_range(15, 0)) : -1;
        for (k = 0; k < 16; k++) begin
            if (k == spoil) begin
                cls = $urandom_range(1, 0) ? SMP_NOISE : SMP_START;
            end else if (k % 2 == 0) begin
                cls = SMP_SPACE;
            end else begin
                cls = value[k / 2] ? SMP_ONE : SMP_ZERO;
            end
            issue(tick_req(cls));
        end
    endtask

    // Mostly well-formed received bytes, with sends, reads, noise, starts,
    // bits without a space in front and the unused kind mixed in.
    task automatic run_mix(input int n_items);
        int issued;
        int pick;
        issued = 0;
        while (issued < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 35) begin
                feed_rx_byte(8'($urandom), $urandom_range(9, 0) == 0);
                issued += 16;
            end else begin
                if (pick < 55) begin
                    issue(rand_req(KIND_SEND));
                end else if (pick < 70) begin
                    issue(rand_req(KIND_READ));
                end else if (pick < 88) begin
                    issue(tick_req(SMP_NOISE));
                end else if (pick < 95) begin
                    issue(tick_req($urandom_range(1, 0) ? SMP_START : SMP_ONE));
                end else begin
                    issue(rand_req(KIND_UNUSED));
                end
                issued++;
            end
        end
    endtask

    // Registers change only with the block drained.
    task automatic run_phase(input int th, input int iv, input int n_items, input int idle);
        wait_all_results();
        write_reg(REG_THRESHOLD, 32'(th));
        write_reg(REG_TX_INTERVAL, 32'(iv));
        gap_pct   = idle;
        stall_pct = idle;
        n_settings++;
        run_mix(n_items);
    endtask

    initial begin
        // reset held low at the start, then released for good
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings (threshold 512, interval 1), no idling.
        issue(rand_req(KIND_READ));              // read with nothing received
        issue(rand_req(KIND_UNUSED));            // unused kind
        issue('{kind: KIND_SEND, pos_sample: 10'h3FF, neg_sample: 10'h3FF, tx_byte: 8'h00});
        issue('{kind: KIND_SEND, pos_sample: 10'h000, neg_sample: 10'h000, tx_byte: 8'hFF});
        issue(tick_at(1023, 0));                 // one, right after reset's space
        issue(tick_at(1023, 0));                 // one again with no space: dropped
        issue(tick_at(0, 0));                    // space
        issue(tick_at(0, 1023));                 // zero
        issue(tick_at(1023, 1023));              // start: ignored
        issue(tick_at(512, 512));                // both at threshold: space
        issue(tick_at(513, 512));                // neg at threshold with pos above: start
        issue(tick_at(513, 511));                // one, space still seen
        issue(tick_at(512, 513));                // zero without a space: dropped
        issue(tick_at(0, 0));
        issue(tick_at(512, 513));                // zero accepted
        issue(rand_req(KIND_READ));              // fewer than 8 bits: no byte
        issue(rand_req(KIND_SEND));

        // Random phases across register settings, extremes first.
        run_phase(512, 1, MIX_ITEMS, 0);         // stretch with no idling
        run_phase(0, 1, MIX_ITEMS, $urandom_range(40, 5));
        run_phase(1023, 2, MIX_ITEMS, $urandom_range(40, 5));
        run_phase(1, 0, MIX_ITEMS, $urandom_range(40, 5));    // interval 0 acts as 1
        run_phase(1022, 65535, 40, $urandom_range(40, 5));    // transmitter never fires
        run_phase($urandom_range(1000, 20), $urandom_range(6, 1), MIX_ITEMS,
                  $urandom_range(40, 5));
        run_phase(511, 3, MIX_ITEMS, $urandom_range(40, 5));

        // Fill both queues past capacity. The output side holds off for a
        // long stretch while sends keep coming, so the block stalls its input.
        wait_all_results();
        write_reg(REG_THRESHOLD, 32'(THRESHOLD_RST));
        write_reg(REG_TX_INTERVAL, 32'(INTERVAL_RST));
        n_settings++;
        gap_pct   = 20;
        stall_pct = 20;
        hold_asked++;
        repeat (FILL_BYTES) issue(rand_req(KIND_SEND));
        // these ticks also drain the full transmit queue
        repeat (FILL_BYTES) feed_rx_byte(8'($urandom), 1'b0);
        repeat (FILL_BYTES) issue(rand_req(KIND_READ));

        // closing phase without any idling
        run_phase($urandom_range(900, 100), 1, 120, 0);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run: %0d requests under %0d register settings (%0d writes), %0d results checked.",
                 n_requests, n_settings, n_writes, chk_results);
        $display("Received bytes read back: %0d; overflow results: %0d; long hold-offs: %0d.",
                 chk_bytes_read, chk_overflows, hold_served);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
